>>> sv/wmsm_pkg.sv
// Shared constants and types for the wildcard mask stream matcher.
// No dependencies.
package wmsm_pkg;

    // Special byte codes
    localparam logic [7:0] WILD_CHAR = 8'h3F;   // '?'
    localparam logic [7:0] CR_CHAR   = 8'h0D;
    localparam logic [7:0] LF_CHAR   = 8'h0A;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx REG_MASK_LOW  = 2'd0;
    localparam t_cfg_idx REG_MASK_HIGH = 2'd1;
    localparam t_cfg_idx REG_MASK_LEN  = 2'd2;

    localparam int unsigned CFG_W      = 64;
    localparam int unsigned MLEN_W     = 5;
    localparam int unsigned LINE_W     = 32;
    localparam int unsigned START_W    = 16;
    localparam int unsigned OUT_DATA_W = LINE_W + START_W;

    typedef logic [OUT_DATA_W-1:0] t_result;

endpackage

>>> sv/wildcard_mask_stream_matcher_top.sv
// Top level of the wildcard mask stream matcher: input register, single-pass
// window compare, two-entry result queue. Depends on wmsm_pkg.
//
// Usage:
//   Slave stream carries the text, one byte per beat: tdata = text_byte,
//   tuser = line_begin (high on the first byte of each line).
//   Master stream carries one beat per match: tdata = {match_start,
//   line_number}, line_number in bits 31:0, match_start in bits 47:32.
//   Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 mask chars 0..7, 1 mask chars 8..15, 2 mask length). Write only while
//   the stream is idle. '?' in the mask matches any byte but CR and LF.
//   Throughput: one text byte per cycle while the result queue can take a match.
//   The compare of all mask positions against the shift window is one level of
//   logic between the input register and the result queue.
//   A beat is compared in the input register; its match is registered in the result queue.
//   Stall: the two-entry result queue keeps taking bytes while one match
//   waits; tready drops only when both entries and the input register hold.
//   Reset (i_rst_n low, synchronous): window cleared, line counter all ones,
//   mask registers to zero with length 1, queue and input register empty.
//   Matches never overlap; past 2^POSITION_BITS-1 bytes a line gives no more matches.
module wildcard_mask_stream_matcher_top
    import wmsm_pkg::*;
#(
    parameter int MAX_MASK_LEN  = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // text in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] text_byte
    input  logic                  i_s_axis_tuser,   // [0] line_begin
    // matches out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [31:0] line_number, [47:32] match_start
    // config
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int WIN_IW = (MAX_MASK_LEN > 1) ? $clog2(MAX_MASK_LEN) : 1;
    localparam int PB     = POSITION_BITS;

    // configuration
    logic [CFG_W-1:0]  r_mask_low;
    logic [CFG_W-1:0]  r_mask_high;
    logic [MLEN_W-1:0] r_mask_len;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_begin;

    // scan state
    logic [7:0]        r_win [0:MAX_MASK_LEN-1];  // newest byte at slot 0
    logic [PB-1:0]     r_pos;
    logic [PB-1:0]     r_nas;                     // earliest next match start
    logic [LINE_W-1:0] r_line;

    // result queue, slot 0 drives the port
    logic    r_q_v0, r_q_v1;
    t_result r_q_d0, r_q_d1;

    logic    n_q_v0, n_q_v1;
    t_result n_q_d0, n_q_d1;

    logic              w_pop, w_adv, w_push, w_hit, w_sat;
    logic [7:0]        w_win [0:MAX_MASK_LEN-1];
    logic [PB-1:0]     w_pos_eff, w_nas_eff;
    logic [LINE_W-1:0] w_line_eff;
    logic [PB:0]       w_pos_p1, w_len_ext, w_start;
    logic [MLEN_W-1:0] w_len;
    logic [127:0]      w_mask;
    logic [PB+START_W:0] w_start_wide;

    assign w_pop  = r_q_v0 & i_m_axis_tready;
    assign w_adv  = r_in_valid & (~r_q_v1 | w_pop);
    assign w_push = w_adv & w_hit;

    assign o_s_axis_tready = ~r_in_valid | w_adv;
    assign o_m_axis_tvalid = r_q_v0;
    assign o_m_axis_tdata  = r_q_d0;

    // line begin clears position state before the byte counts
    assign w_line_eff = r_in_begin ? r_line + 1'b1 : r_line;
    assign w_pos_eff  = r_in_begin ? '0 : r_pos;
    assign w_nas_eff  = r_in_begin ? '0 : r_nas;
    assign w_sat      = &w_pos_eff;
    assign w_pos_p1   = {1'b0, w_pos_eff} + 1'b1;

    assign w_len     = (r_mask_len > MLEN_W'(MAX_MASK_LEN)) ? MLEN_W'(MAX_MASK_LEN)
                                                            : r_mask_len;
    assign w_len_ext = (PB+1)'(w_len);
    assign w_start   = w_pos_p1 - w_len_ext;
    assign w_mask    = {r_mask_high, r_mask_low};
    assign w_start_wide = {{START_W{1'b0}}, w_start};

    // window after the current byte is shifted in
    always_comb begin
        w_win[0] = r_in_byte;
        for (int j = 1; j < MAX_MASK_LEN; j++) begin
            w_win[j] = r_win[j-1];
        end
    end

    // mask char k lines up with window slot len-1-k
    always_comb begin
        logic [MLEN_W-1:0] slot;
        logic [7:0]        t;
        logic [7:0]        m;
        w_hit = (w_len != '0) && !w_sat && (w_pos_p1 >= w_len_ext)
                && (w_start >= {1'b0, w_nas_eff});
        for (int k = 0; k < MAX_MASK_LEN; k++) begin
            slot = w_len - 1'b1 - MLEN_W'(k);
            t    = w_win[slot[WIN_IW-1:0]];
            m    = w_mask[8*k +: 8];
            if (MLEN_W'(k) < w_len) begin
                if (t == CR_CHAR || t == LF_CHAR) begin
                    w_hit = 1'b0;
                end else if (m != WILD_CHAR && m != t) begin
                    w_hit = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_q_v0 = r_q_v0;
        n_q_v1 = r_q_v1;
        n_q_d0 = r_q_d0;
        n_q_d1 = r_q_d1;
        if (w_pop) begin
            n_q_v0 = r_q_v1;
            n_q_d0 = r_q_d1;
            n_q_v1 = 1'b0;
        end
        if (w_push) begin
            if (!n_q_v0) begin
                n_q_v0 = 1'b1;
                n_q_d0 = {w_start_wide[START_W-1:0], w_line_eff};
            end else begin
                n_q_v1 = 1'b1;
                n_q_d1 = {w_start_wide[START_W-1:0], w_line_eff};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_low  <= '0;
            r_mask_high <= '0;
            r_mask_len  <= MLEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MASK_LOW:  r_mask_low  <= i_cfg_data;
                REG_MASK_HIGH: r_mask_high <= i_cfg_data;
                REG_MASK_LEN:  r_mask_len  <= i_cfg_data[MLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_begin <= i_s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_MASK_LEN; j++) begin
                r_win[j] <= '0;
            end
            r_pos  <= '0;
            r_nas  <= '0;
            r_line <= '1;
        end else if (w_adv) begin
            for (int j = 0; j < MAX_MASK_LEN; j++) begin
                r_win[j] <= w_win[j];
            end
            r_pos  <= w_sat ? w_pos_eff : w_pos_p1[PB-1:0];
            r_nas  <= w_hit ? w_pos_p1[PB-1:0] : w_nas_eff;
            r_line <= w_line_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v0 <= 1'b0;
            r_q_v1 <= 1'b0;
        end else begin
            r_q_v0 <= n_q_v0;
            r_q_v1 <= n_q_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_d0 <= n_q_d0;
        r_q_d1 <= n_q_d1;
    end

`ifndef SYNTH
    // a match is only pushed when the queue has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!r_q_v1 || w_pop))
        else $error("result queue overflow");

    // the back slot never holds a beat while the front slot is empty
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_v1 |-> r_q_v0)
        else $error("result queue out of order");

    // matches never overlap the previous one
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_start >= {1'b0, w_nas_eff}))
        else $error("overlapping match");

    // within a line the position never goes backward
    a_pos_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_begin) |=> (r_pos >= $past(r_pos)))
        else $error("line position went backward");
`endif

endmodule

>>> tb/wildcard_mask_stream_matcher_top_tb.sv
// Self-checking bench for wildcard_mask_stream_matcher_top: streams text beats,
// predicts every match in a scoreboard class and checks the result stream.
// Depends on wmsm_pkg and the matcher RTL.
`timescale 1ns / 100ps

module wildcard_mask_stream_matcher_top_tb;
    import wmsm_pkg::*;

    localparam int unsigned MASK_SLOTS   = 16;
    localparam int unsigned POS_MAX      = 16'hFFFF;
    localparam int unsigned DRAIN_CYCLES = 8;       // idle slack after the last predicted match
    localparam int unsigned HOLD_CYCLES  = 150;     // long receiver hold-off
    localparam int unsigned N_PHASES     = 10;
    localparam int unsigned PHASE_ITEMS  = 165;
    localparam int unsigned MAX_REPORTS  = 30;
    localparam int unsigned CYCLE_LIMIT  = 3000000;

    // ------------------------------------------------------------------
    // Match predictor and store of expected matches
    // ------------------------------------------------------------------
    class match_scoreboard;
        logic [CFG_W-1:0]   mask_lo;
        logic [CFG_W-1:0]   mask_hi;
        logic [MLEN_W-1:0]  mask_len;
        logic [7:0]         window [MASK_SLOTS];   // newest byte at 0
        logic [15:0]        line_pos;
        logic [16:0]        next_start;
        logic [LINE_W-1:0]  line_cnt;
        t_result            expected_q [$];
        int                 errors;
        int                 beats;
        int                 hits;

        function new();
            mask_lo    = '0;
            mask_hi    = '0;
            mask_len   = MLEN_W'(1);
            foreach (window[i]) window[i] = 8'h00;
            line_pos   = '0;
            next_start = '0;
            line_cnt   = '1;
            errors     = 0;
            beats      = 0;
            hits       = 0;
        endfunction

        function void configure(logic [127:0] chars, logic [MLEN_W-1:0] len);
            mask_lo  = chars[63:0];
            mask_hi  = chars[127:64];
            mask_len = len;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // One accepted text beat; pushes the match it completes, if any.
        function void note_beat(logic [7:0] b, logic lb);
            int unsigned pos;
            int unsigned len;
            int unsigned k;
            bit          hit;
            logic [7:0]  t;
            logic [7:0]  m;
            logic [127:0] chars;
            logic [START_W-1:0] st;
            beats++;
            if (lb) begin
                line_cnt   = line_cnt + 1'b1;
                line_pos   = '0;
                next_start = '0;
            end
            for (int i = MASK_SLOTS - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = b;
            pos = line_pos;
            // saturated position: no increment and no match
            if (pos >= POS_MAX) return;
            line_pos = line_pos + 1'b1;
            len = (mask_len > MASK_SLOTS) ? MASK_SLOTS : mask_len;
            if (len == 0 || pos + 1 < len) return;
            if (pos + 1 - len < next_start) return;
            chars = {mask_hi, mask_lo};
            hit = 1'b1;
            for (k = 0; k < len; k++) begin
                t = window[len - 1 - k];
                m = chars[8*k +: 8];
                if (t == CR_CHAR || t == LF_CHAR) hit = 1'b0;
                else if (m != WILD_CHAR && m != t) hit = 1'b0;
            end
            if (!hit) return;
            next_start = 17'(pos + 1);
            st = START_W'(pos + 1 - len);
            expected_q.push_back({st, line_cnt});
        endfunction

        // One accepted match beat against the oldest expectation.
        function void check_match(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected match line %0d start %0d", $time,
                             got[LINE_W-1:0], got[OUT_DATA_W-1:LINE_W]);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            hits++;
            if (got[LINE_W-1:0] !== want[LINE_W-1:0]) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: line_number expected %0d actual %0d", $time,
                             want[LINE_W-1:0], got[LINE_W-1:0]);
                errors++;
            end
            if (got[OUT_DATA_W-1:LINE_W] !== want[OUT_DATA_W-1:LINE_W]) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: match_start expected %0d actual %0d", $time,
                             want[OUT_DATA_W-1:LINE_W], got[OUT_DATA_W-1:LINE_W]);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; the ones the bench drives are known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk    = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_valid  = 1'b0;
    logic [7:0]            s_data   = 8'h00;
    logic                  s_user   = 1'b0;
    logic                  m_ready  = 1'b0;
    logic                  cfg_we   = 1'b0;
    t_cfg_idx              cfg_idx  = REG_MASK_LOW;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    match_scoreboard sb;
    int          tx_gap_pct   = 25;
    int          rx_stall_pct = 25;
    bit          hold_req     = 1'b0;
    int          settings     = 0;
    int unsigned cycles       = 0;
    logic [127:0] phase_chars = '0;
    int unsigned  phase_len   = 1;

    wildcard_mask_stream_matcher_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Monitor: values seen here are the ones before this edge's updates.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (o_m_axis_tvalid && m_ready) sb.check_match(o_m_axis_tdata);
            if (s_valid && o_s_axis_tready) sb.note_beat(s_data, s_user);
        end
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin : rx_proc
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                m_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Offer one text beat, hold it until accepted, then maybe idle a burst.
    task automatic send_beat(input logic [7:0] b, input logic lb);
        s_valid <= 1'b1;
        s_data  <= b;
        s_user  <= lb;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every predicted match has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers back to back; only called while idle.
    task automatic load_mask(input logic [127:0] chars, input int unsigned len);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_MASK_LOW;
        cfg_data <= chars[63:0];
        @(posedge i_clk);
        cfg_idx  <= REG_MASK_HIGH;
        cfg_data <= chars[127:64];
        @(posedge i_clk);
        cfg_idx  <= REG_MASK_LEN;
        cfg_data <= CFG_W'(len[MLEN_W-1:0]);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sb.configure(chars, len[MLEN_W-1:0]);
        phase_chars = chars;
        phase_len   = (len[MLEN_W-1:0] > MASK_SLOTS) ? MASK_SLOTS : len[MLEN_W-1:0];
        settings++;
    endtask

    function automatic logic [7:0] pick_mask_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 8'h61 + 8'($urandom_range(0, 2));   // a, b, c
        if (r < 85) return WILD_CHAR;
        if (r < 97) return 8'($urandom_range(0, 255));
        return ($urandom_range(0, 1) != 0) ? CR_CHAR : LF_CHAR;
    endfunction

    function automatic logic [7:0] pick_text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            case ($urandom_range(0, 3))
                0: return 8'h61;
                1: return 8'h62;
                2: return 8'h63;
                default: return WILD_CHAR;
            endcase
        end
        if (r < 90) return 8'($urandom_range(0, 255));
        return ($urandom_range(0, 1) != 0) ? CR_CHAR : LF_CHAR;
    endfunction

    // Mostly whole lines seeded with mask instances, some loose noise beats.
    task automatic run_text_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned llen;
        logic [7:0]  c;
        logic [7:0]  line_q [$];
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 85) begin
                llen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80)
                                                   : $urandom_range(1, 24);
                line_q.delete();
                while (line_q.size() < llen) begin
                    if (phase_len != 0 && $urandom_range(0, 3) == 0) begin
                        for (int k = 0; k < phase_len; k++) begin
                            c = phase_chars[8*k +: 8];
                            if (c == WILD_CHAR) begin
                                // wildcard slot: any byte, now and then a line break
                                do c = 8'($urandom_range(0, 255));
                                while (c == CR_CHAR || c == LF_CHAR);
                                if ($urandom_range(0, 9) == 0) c = CR_CHAR;
                            end
                            line_q.push_back(c);
                        end
                    end else begin
                        line_q.push_back(pick_text_char());
                    end
                end
                foreach (line_q[i]) begin
                    send_beat(line_q[i], i == 0);
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [127:0] chars;
        int unsigned  len_w;
        sb = new();
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset mask is one 0x00 char; bytes before any line begin report line all ones.
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b1);
        wait_drained();

        // "a?a": wildcard, no overlap after a match, wildcard never takes CR.
        load_mask(128'h613F61, 3);
        send_beat("a", 1'b1);
        send_beat("x", 1'b0);
        send_beat("a", 1'b0);
        send_beat(WILD_CHAR, 1'b0);
        send_beat("a", 1'b0);
        send_beat("a", 1'b0);
        send_beat(CR_CHAR, 1'b0);
        send_beat("a", 1'b0);
        wait_drained();

        // Full-length mask of 0xFF chars.
        load_mask('1, MASK_SLOTS);
        for (int i = 0; i < MASK_SLOTS; i++) send_beat(8'hFF, i == 0);
        wait_drained();

        // Random phases: lengths 1, 16, zero and above 16 among them.
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0, 2:    len_w = 1;
                1:       len_w = MASK_SLOTS;
                3:       len_w = 0;
                4:       len_w = 31;
                5:       len_w = 20;
                default: len_w = $urandom_range(1, MASK_SLOTS);
            endcase
            for (int k = 0; k < MASK_SLOTS; k++) chars[8*k +: 8] = pick_mask_char();
            // hold-off phase: a lone wildcard matches nearly every byte
            if (p == 2) chars[7:0] = WILD_CHAR;
            load_mask(chars, len_w);
            tx_gap_pct   = (p % 3 == 1) ? 0 : 25;
            rx_stall_pct = (p % 4 == 3) ? 0 : 20;
            if (p == N_PHASES - 1) begin
                // tail of the run without idling on either side
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            // receiver holds off while text keeps coming, so the block backs up
            if (p == 2) hold_req = 1'b1;
            run_text_phase(PHASE_ITEMS);
            wait_drained();
        end

        $display("covered %0d text beats and %0d matches over %0d mask settings,",
                 sb.beats, sb.hits, settings);
        $display("with zero, full and oversized mask lengths and a long receiver hold-off");
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
